@@ design/phc_pkg.sv @@
// Shared widths, register indexes, sequencer states and result record
// for the half-plane polygon clipper. No dependencies.
package phc_pkg;

	localparam int COORD_W = 32;                 // Q16.16 coordinates
	localparam int FRAC_W  = 16;
	localparam int DIST_W  = 2 * COORD_W + 2;    // exact signed distance
	localparam int MAG_W   = DIST_W - 1;         // distance magnitude
	localparam int DLT_W   = COORD_W + 1;        // edge delta, signed
	localparam int MUL_W   = DLT_W + 1;          // signed multiplier operand
	localparam int PROD_W  = 2 * MUL_W;
	localparam int HI_W    = MAG_W - DLT_W;      // upper chunk of magnitude
	localparam int NUM_W   = MAG_W + DLT_W;      // crossing numerator
	localparam int QUO_W   = DLT_W;              // quotient never exceeds |delta|
	localparam int CNT_W   = $clog2(QUO_W + 1);
	localparam int IDX_W   = 2;

	localparam logic [IDX_W-1:0] REG_NORMAL_X     = 2'd0;
	localparam logic [IDX_W-1:0] REG_NORMAL_Y     = 2'd1;
	localparam logic [IDX_W-1:0] REG_PLANE_OFFSET = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_D0,
		S_D1,
		S_D2,
		S_START,
		S_EA,
		S_CR0,
		S_CR1,
		S_DLT,
		S_NUM0,
		S_NUM1,
		S_NUM2,
		S_DIV,
		S_FIX,
		S_EEND,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic               is_vertex;
		logic               eop;
	} res_t;

endpackage

@@ design/polygon_halfplane_clip_top.sv @@
// Half-plane polygon clipper, single sequenced datapath with one shared
// multiplier and one serial divider. Depends on phc_pkg.
//
// Usage:
//   Slave stream s_*: one polygon vertex per request, x and y in tdata,
//   tlast marks the final vertex. Master stream m_*: clipped vertices,
//   tuser = is_vertex, tlast = end of clipped polygon. A polygon whose final
//   vertex leaves nothing to close yields one empty marker (tuser low).
//   Config port: cfg_we/cfg_index/cfg_data write normal_x (0), normal_y (1)
//   and plane_offset (2); index 3 is ignored. Write only while idle.
// Timing:
//   s_tready is high only in the idle state. Per vertex: an accept step, the
//   distance (two products on the shared 34x34 multiplier), setup and retire;
//   each edge adds a start and an end step; a crossing adds a denominator
//   setup, then per coordinate: delta, two partial products, sum, 33
//   restoring-divide steps, fix-up. The serial divider sets the rate, plus
//   output stalls; no new vertex is accepted until the last one retires.
// Reset: arst_n clears the plane and control registers and the sequencer.
// Stall: results wait in a one-deep hold plus the output register; while that
//   register is full and m_tready is low the sequencer parks at its next result.
module polygon_halfplane_clip_top
	import phc_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// configuration write port
	input  logic                 cfg_we,
	input  logic [IDX_W-1:0]     cfg_index,
	input  logic [COORD_W-1:0]   cfg_data,
	// vertex input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*COORD_W-1:0] s_tdata,   // [31:0] vertex_x, [63:32] vertex_y
	input  logic                 s_tlast,   // final_vertex
	// clipped output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [2*COORD_W-1:0] m_tdata,   // [31:0] out_x, [63:32] out_y
	output logic                 m_tuser,   // is_vertex
	output logic                 m_tlast    // end_of_polygon
);

	state_t state_q, state_d;

	// plane registers
	logic [COORD_W-1:0] normal_x_q, normal_y_q, offset_q;

	// current vertex and its distance
	logic [COORD_W-1:0] cur_x_q, cur_y_q;
	logic               cur_fin_q;
	logic [DIST_W-1:0]  dist_q;

	// polygon state
	logic [COORD_W-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q;
	logic [DIST_W-1:0]  first_d_q, prev_d_q;
	logic               mid_q;

	// shared datapath
	logic signed [PROD_W-1:0] mul_q;
	logic [MAG_W-1:0]   mag_q;
	logic [DIST_W-1:0]  den_q;
	logic [DLT_W-1:0]   md_q;
	logic               neg_q;
	logic [NUM_W-1:0]   num_q, dsh_q;
	logic [QUO_W-1:0]   quo_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [COORD_W-1:0] cx_q;
	logic               coord_q;    // 0: x, 1: y
	logic               edge_q;     // 0: prev->cur, 1: cur->first (closing)

	// hold and output stages
	res_t pend_q, out_q;
	logic pend_v_q, out_v_q;

	// edge operands
	logic [COORD_W-1:0] ax, ay, bx, by, a_c, b_c;
	logic [DIST_W-1:0]  da, db;
	logic               a_out, b_out;

	always_comb begin
		ax = edge_q ? cur_x_q : prev_x_q;
		ay = edge_q ? cur_y_q : prev_y_q;
		da = edge_q ? dist_q  : prev_d_q;
		bx = edge_q ? first_x_q : cur_x_q;
		by = edge_q ? first_y_q : cur_y_q;
		db = edge_q ? first_d_q : dist_q;
		a_c = coord_q ? ay : ax;
		b_c = coord_q ? by : bx;
		// outside means strictly positive distance
		a_out = !da[DIST_W-1] && (da != '0);
		b_out = !db[DIST_W-1] && (db != '0);
	end

	// shared multiplier operands
	logic [MUL_W-1:0] mop_a, mop_b;

	always_comb begin
		case (state_q)
			S_D0: begin
				mop_a = {{(MUL_W-COORD_W){cur_x_q[COORD_W-1]}}, cur_x_q};
				mop_b = {{(MUL_W-COORD_W){normal_x_q[COORD_W-1]}}, normal_x_q};
			end
			S_D1: begin
				mop_a = {{(MUL_W-COORD_W){cur_y_q[COORD_W-1]}}, cur_y_q};
				mop_b = {{(MUL_W-COORD_W){normal_y_q[COORD_W-1]}}, normal_y_q};
			end
			S_NUM1: begin
				mop_a = {{(MUL_W-HI_W){1'b0}}, mag_q[MAG_W-1:DLT_W]};
				mop_b = {1'b0, md_q};
			end
			default: begin
				mop_a = {1'b0, mag_q[DLT_W-1:0]};
				mop_b = {1'b0, md_q};
			end
		endcase
	end

	// distance terms
	logic [DIST_W-1:0] prod_d, off_ext;
	assign prod_d  = mul_q[DIST_W-1:0];
	assign off_ext = {{(DIST_W-COORD_W-FRAC_W){offset_q[COORD_W-1]}}, offset_q,
		{FRAC_W{1'b0}}};

	// crossing setup
	logic [DLT_W-1:0] dlt;
	assign dlt = {b_c[COORD_W-1], b_c} - {a_c[COORD_W-1], a_c};

	// divider step: one wide compare-subtract
	logic [NUM_W:0] diff;
	logic           ge;
	assign diff = {1'b0, num_q} - {1'b0, dsh_q};
	assign ge   = !diff[NUM_W];

	// crossing coordinate
	logic [COORD_W-1:0] qlow, cross_c;
	assign qlow    = quo_q[COORD_W-1:0];
	assign cross_c = a_c + (neg_q ? (~qlow + 1'b1) : qlow);

	// sequencer control
	logic out_free, put_req, stall, ld_out, pend_ld;
	res_t put_res, ld_res;

	assign out_free = !out_v_q || m_tready;

	always_comb begin
		state_d = state_q;
		put_req = 1'b0;
		put_res = '{x: ax, y: ay, is_vertex: 1'b1, eop: 1'b0};
		ld_out  = 1'b0;
		ld_res  = '{x: pend_q.x, y: pend_q.y, is_vertex: 1'b1, eop: 1'b0};
		stall   = 1'b0;

		if (state_q == S_EA && !a_out) begin
			put_req = 1'b1;
		end
		if (state_q == S_FIX && coord_q) begin
			put_req = 1'b1;
			put_res = '{x: cx_q, y: cross_c, is_vertex: 1'b1, eop: 1'b0};
		end

		if (put_req && pend_v_q) begin
			stall  = !out_free;
			ld_out = out_free;
		end
		if (state_q == S_DONE && (cur_fin_q || pend_v_q)) begin
			stall  = !out_free;
			ld_out = out_free;
			if (pend_v_q) begin
				ld_res.eop = cur_fin_q;
			end else begin
				// nothing survived: empty end marker
				ld_res = '{x: '0, y: '0, is_vertex: 1'b0, eop: 1'b1};
			end
		end
		pend_ld = put_req && !stall;

		unique case (state_q)
			S_IDLE:  if (s_tvalid) state_d = S_D0;
			S_D0:    state_d = S_D1;
			S_D1:    state_d = S_D2;
			S_D2:    state_d = S_START;
			S_START: begin
				if (mid_q || cur_fin_q) state_d = S_EA;
				else                    state_d = S_DONE;
			end
			S_EA: if (!stall) state_d = (a_out != b_out) ? S_CR0 : S_EEND;
			S_CR0:   state_d = S_CR1;
			S_CR1:   state_d = S_DLT;
			S_DLT:   state_d = S_NUM0;
			S_NUM0:  state_d = S_NUM1;
			S_NUM1:  state_d = S_NUM2;
			S_NUM2:  state_d = S_DIV;
			S_DIV:   if (cnt_q == CNT_W'(1)) state_d = S_FIX;
			S_FIX: begin
				if (!coord_q)    state_d = S_DLT;
				else if (!stall) state_d = S_EEND;
			end
			S_EEND: begin
				if (!edge_q && cur_fin_q) state_d = S_EA;
				else                      state_d = S_DONE;
			end
			S_DONE: if (!stall) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			normal_x_q <= '0;
			normal_y_q <= '0;
			offset_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NORMAL_X:     normal_x_q <= cfg_data;
				REG_NORMAL_Y:     normal_y_q <= cfg_data;
				REG_PLANE_OFFSET: offset_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mid_q    <= 1'b0;
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
			edge_q   <= 1'b0;
			coord_q  <= 1'b0;
			cnt_q    <= '0;
		end else begin
			if (ld_out)        out_v_q <= 1'b1;
			else if (m_tready) out_v_q <= 1'b0;

			if (pend_ld) pend_v_q <= 1'b1;

			case (state_q)
				S_START: edge_q <= !mid_q;   // first vertex: closing edge only
				S_EA:    coord_q <= 1'b0;
				S_NUM2:  cnt_q <= CNT_W'(QUO_W);
				S_DIV:   cnt_q <= cnt_q - 1'b1;
				S_FIX:   if (!coord_q) coord_q <= 1'b1;
				S_EEND:  begin
					edge_q <= 1'b1;
				end
				S_DONE: if (!stall) begin
					pend_v_q <= 1'b0;
					mid_q    <= !cur_fin_q;
				end
				default: ;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_q <= $signed(mop_a) * $signed(mop_b);

		if (ld_out)  out_q  <= ld_res;
		if (pend_ld) pend_q <= put_res;

		case (state_q)
			S_IDLE: begin
				cur_x_q   <= s_tdata[COORD_W-1:0];
				cur_y_q   <= s_tdata[2*COORD_W-1:COORD_W];
				cur_fin_q <= s_tlast;
			end
			S_D1: dist_q <= prod_d - off_ext;
			S_D2: dist_q <= dist_q + prod_d;
			S_START: if (!mid_q) begin
				first_x_q <= cur_x_q;
				first_y_q <= cur_y_q;
				first_d_q <= dist_q;
			end
			S_CR0: begin
				den_q <= da - db;
				mag_q <= da[DIST_W-1] ? MAG_W'(~da + 1'b1) : da[MAG_W-1:0];
			end
			S_CR1: if (den_q[DIST_W-1]) den_q <= ~den_q + 1'b1;
			S_DLT: begin
				md_q  <= dlt[DLT_W-1] ? (~dlt + 1'b1) : dlt;
				// denominator sign is negative exactly when a is inside
				neg_q <= da[DIST_W-1] ^ dlt[DLT_W-1] ^ !a_out;
			end
			S_NUM1: num_q <= NUM_W'(mul_q[2*DLT_W-1:0]);
			S_NUM2: begin
				num_q <= num_q + (NUM_W'(mul_q[2*DLT_W-1:0]) << DLT_W);
				dsh_q <= NUM_W'(den_q[MAG_W-1:0]) << (QUO_W - 1);
				quo_q <= '0;
			end
			S_DIV: begin
				if (ge) num_q <= diff[NUM_W-1:0];
				quo_q <= {quo_q[QUO_W-2:0], ge};
				dsh_q <= dsh_q >> 1;
			end
			S_FIX: if (!coord_q) cx_q <= cross_c;
			S_DONE: if (!stall) begin
				prev_x_q <= cur_x_q;
				prev_y_q <= cur_y_q;
				prev_d_q <= dist_q;
			end
			default: ;
		endcase
	end

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_v_q;
	assign m_tdata  = {out_q.y, out_q.x};
	assign m_tuser  = out_q.is_vertex;
	assign m_tlast  = out_q.eop;

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for polygon_halfplane_clip_top: streams polygons, predicts
// the clipped output per vertex and compares every result request.
// Depends on phc_pkg and polygon_halfplane_clip_top.
module tb_top;
	import phc_pkg::*;

	localparam int                CLK_HALF     = 2;
	localparam int                DRAIN_CYCLES = 200;     // longer than the worst-case vertex
	localparam int                LIMIT        = 1000000;
	localparam int                PHASE_ITEMS  = 107;
	localparam logic [IDX_W-1:0]  REG_UNUSED   = 2'd3;    // outside the register map

	// Expected-result store and half-plane clip predictor.
	class clip_scoreboard;
		res_t               pending[$];
		logic signed [31:0] nx, ny, off;
		logic signed [31:0] first_x, first_y, prev_x, prev_y;
		logic signed [127:0] first_d, prev_d;
		bit                 mid;
		int                 errors;

		function new();
			nx = 0; ny = 0; off = 0;
			first_x = 0; first_y = 0; prev_x = 0; prev_y = 0;
			first_d = 0; prev_d = 0;
			mid = 0;
			errors = 0;
		endfunction

		function void write_reg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
			case (idx)
				REG_NORMAL_X:     nx = val;
				REG_NORMAL_Y:     ny = val;
				REG_PLANE_OFFSET: off = val;
				default: ;
			endcase
		endfunction

		// exact signed distance, scale 2^(2*FRAC_W)
		function logic signed [127:0] plane_dist(logic signed [31:0] x, logic signed [31:0] y);
			logic signed [127:0] wx, wy, wnx, wny, wo;
			wx = x; wy = y; wnx = nx; wny = ny; wo = off;
			return wx * wnx + wy * wny - (wo <<< FRAC_W);
		endfunction

		// a + trunc(da * (b - a) / (da - db)); SV signed divide truncates toward zero
		function logic [31:0] cross_coord(logic signed [31:0] a, logic signed [31:0] b,
		                                  logic signed [127:0] da, logic signed [127:0] db);
			logic signed [127:0] wa, wb, q;
			wa = a; wb = b;
			q = (da * (wb - wa)) / (da - db);
			return 32'(wa + q);
		endfunction

		function void add_point(logic [31:0] x, logic [31:0] y);
			res_t r;
			r.x = x; r.y = y; r.is_vertex = 1'b1; r.eop = 1'b0;
			pending.insert(pending.size(), r);
		endfunction

		function void clip_edge(logic signed [31:0] ax, logic signed [31:0] ay,
		                        logic signed [127:0] da, logic signed [31:0] bx,
		                        logic signed [31:0] by, logic signed [127:0] db);
			bit a_out, b_out;
			a_out = da > 0;
			b_out = db > 0;
			if (!a_out)
				add_point(ax, ay);
			if (a_out != b_out)
				add_point(cross_coord(ax, bx, da, db), cross_coord(ay, by, da, db));
		endfunction

		// one accepted vertex request
		function void note_vertex(logic signed [31:0] x, logic signed [31:0] y, bit fin);
			logic signed [127:0] d;
			int                  n0;
			res_t                r;
			d = plane_dist(x, y);
			n0 = pending.size();
			if (!mid) begin
				first_x = x; first_y = y; first_d = d;
			end else begin
				clip_edge(prev_x, prev_y, prev_d, x, y, d);
			end
			prev_x = x; prev_y = y; prev_d = d;
			mid = 1;
			if (fin) begin
				clip_edge(x, y, d, first_x, first_y, first_d);
				if (pending.size() == n0) begin
					r.x = '0; r.y = '0; r.is_vertex = 1'b0; r.eop = 1'b1;
				end else begin
					r = pending.pop_back();
					r.eop = 1'b1;
				end
				pending.insert(pending.size(), r);
				mid = 0;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(logic [2*COORD_W-1:0] data, logic user, logic last);
			res_t exp_r;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result x=%h y=%h vtx=%b eop=%b",
				                 data[31:0], data[63:32], user, last));
				return;
			end
			exp_r = pending.pop_front();
			if (data[31:0] !== exp_r.x)
				report($sformatf("out_x got %h want %h", data[31:0], exp_r.x));
			if (data[63:32] !== exp_r.y)
				report($sformatf("out_y got %h want %h", data[63:32], exp_r.y));
			if (user !== exp_r.is_vertex)
				report($sformatf("is_vertex got %b want %b", user, exp_r.is_vertex));
			if (last !== exp_r.eop)
				report($sformatf("end_of_polygon got %b want %b", last, exp_r.eop));
		endtask
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [IDX_W-1:0]     cfg_index;
	logic [COORD_W-1:0]   cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [2*COORD_W-1:0] s_tdata;
	logic                 s_tlast;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [2*COORD_W-1:0] m_tdata;
	logic                 m_tuser;
	logic                 m_tlast;

	clip_scoreboard sb;
	int             tx_idle_pct;   // sender idle chance per cycle
	int             rx_stall_pct;  // receiver stall chance per cycle
	int             rx_hold;       // long receiver hold-off, counted down by the receiver
	int             cycle_cnt;

	polygon_halfplane_clip_top u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #(CLK_HALF) clk = ~clk;
	end

	// Receiver: ready moves on the falling edge; a hold-off request wins over
	// the random stall so the block backs up into its input.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (rx_hold > 0) begin
				m_tready = 1'b0;
				rx_hold--;
			end else begin
				m_tready = ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	// Result requests are checked at the rising edge they complete on.
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata, m_tuser, m_tlast);
	end

	// Watchdog
	initial begin
		cycle_cnt = 0;
		while (cycle_cnt < LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("polygon_halfplane_clip_top verification failed");
		$finish;
	end

	// One vertex request; valid stays up across back-to-back requests.
	task automatic send_vertex(logic [31:0] x, logic [31:0] y, bit fin);
		while ($urandom_range(99) < tx_idle_pct) begin
			@(negedge clk);
			s_tvalid = 1'b0;
		end
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tdata  = {y, x};
		s_tlast  = fin;
		do @(posedge clk); while (!s_tready);
		sb.note_vertex(x, y, fin);
	endtask

	// Stop sending, let every expected result come out, then give the block
	// time to finish a vertex that produces nothing.
	task automatic drain();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_cfg(logic [IDX_W-1:0] idx, logic [COORD_W-1:0] val);
		@(negedge clk);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_data  = val;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.write_reg(idx, val);
	endtask

	task automatic set_plane(logic [31:0] nx, logic [31:0] ny, logic [31:0] off);
		write_cfg(REG_NORMAL_X, nx);
		write_cfg(REG_NORMAL_Y, ny);
		write_cfg(REG_PLANE_OFFSET, off);
	endtask

	function automatic logic [31:0] pick_extreme();
		case ($urandom_range(3))
			0:       return 32'h8000_0000;
			1:       return 32'h7FFF_FFFF;
			2:       return 32'h0000_0000;
			default: return 32'hFFFF_FFFF;
		endcase
	endfunction

	// Mostly coordinates near the plane so edges cross; some full range.
	function automatic logic [31:0] rand_coord();
		case ($urandom_range(9))
			0, 1, 2, 3: return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
			4, 5:       return $urandom();
			6:          return pick_extreme();
			default:    return $urandom_range(0, 32'h07D0_0000) - 32'h03E8_0000;
		endcase
	endfunction

	task automatic rand_plane();
		case ($urandom_range(5))
			0:       set_plane($urandom(), $urandom(), $urandom());
			5:       set_plane(pick_extreme(), pick_extreme(), pick_extreme());
			default: set_plane($urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
			                   $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
			                   $urandom_range(0, 32'h0006_0000) - 32'h0003_0000);
		endcase
	endtask

	// Random polygon, mostly 2..6 vertices, occasionally a lone vertex.
	task automatic rand_polygon(inout int sent);
		int n;
		n = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 6);
		for (int i = 0; i < n; i++)
			send_vertex(rand_coord(), rand_coord(), i == n - 1);
		sent += n;
	endtask

	initial begin
		int sent;
		int polys;
		sb = new();
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_index    = '0;
		cfg_data     = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tlast      = 1'b0;
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		rx_hold      = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// ---- directed ----
		// reset plane: every distance is zero, so every vertex is inside
		send_vertex(32'h0001_0000, 32'h0002_0000, 0);
		send_vertex(32'h0003_0000, 32'h0004_0000, 0);
		send_vertex(32'h0005_0000, 32'h0006_0000, 1);
		drain();
		// inside means x <= 0
		set_plane(32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
		send_vertex(32'hFFFF_0000, 32'h0000_0000, 1);   // lone vertex inside
		send_vertex(32'h0001_0000, 32'h0000_0000, 1);   // lone vertex outside: marker
		// triangle straddling the plane, crossings not on the grid
		send_vertex(32'hFFFF_0000, 32'h0000_0000, 0);
		send_vertex(32'h0002_0000, 32'h0001_0000, 0);
		send_vertex(32'hFFFF_0000, 32'h0003_0000, 1);
		// fully outside: marker
		send_vertex(32'h0001_0000, 32'h0000_0000, 0);
		send_vertex(32'h0002_0000, 32'h0000_0000, 0);
		send_vertex(32'h0002_0000, 32'h0001_0000, 0);
		send_vertex(32'h0001_0000, 32'h0001_0000, 1);
		// earlier edges give results, the final vertex gives nothing: marker
		send_vertex(32'h0001_0000, 32'h0000_0000, 0);
		send_vertex(32'hFFFF_0000, 32'h0000_0000, 0);
		send_vertex(32'h0001_0000, 32'h0001_0000, 0);
		send_vertex(32'h0002_0000, 32'h0002_0000, 1);
		drain();
		// extreme plane and extreme coordinates
		set_plane(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
		send_vertex(32'h7FFF_FFFF, 32'h8000_0000, 0);
		send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 0);
		send_vertex(32'h0000_0000, 32'hFFFF_FFFF, 1);
		drain();
		// plane change in the middle of a polygon; the first vertex keeps the old
		// distance. An unmapped index must change nothing.
		set_plane(32'h0001_0000, 32'h0001_0000, 32'h0000_0000);
		send_vertex(32'h0001_0000, 32'h0001_0000, 0);
		drain();
		write_cfg(REG_PLANE_OFFSET, 32'h7FFF_FFFF);
		write_cfg(REG_UNUSED, 32'hA5A5_5A5A);
		send_vertex(32'hFFFF_0000, 32'h0000_0000, 0);
		send_vertex(32'h0003_8000, 32'hFFFD_4321, 1);
		drain();

		// ---- random phases: none, sender idle, receiver stall, both ----
		for (int ph = 0; ph < 4; ph++) begin
			tx_idle_pct  = (ph == 1) ? 58 : (ph == 3) ? 25 : 0;
			rx_stall_pct = (ph == 2) ? 58 : (ph == 3) ? 25 : 0;
			sent  = 0;
			polys = 0;
			while (sent < PHASE_ITEMS) begin
				if (polys % 8 == 0) begin
					drain();
					if (polys == 0 && ph == 0)
						set_plane(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
					else if (polys == 0 && ph == 1)
						set_plane(32'h0000_0000, 32'h0000_0000, 32'h8000_0000);
					else
						rand_plane();
				end
				// long receiver hold-off while the sender keeps pushing
				if (ph == 0 && polys == 3)
					rx_hold = 600;
				rand_polygon(sent);
				polys++;
			end
		end

		drain();
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("polygon_halfplane_clip_top verification clean");
		else
			$display("polygon_halfplane_clip_top verification failed");
		$finish;
	end

endmodule

@@ files.f @@
design/phc_pkg.sv
design/polygon_halfplane_clip_top.sv
verif/tb_top.sv
